/* hdl/csp_pkg.sv */
// ----------------------------------------------------------------------------
// csp_pkg
// Shared constants, codes and structs of the constrained shortest path block.
// ----------------------------------------------------------------------------
package csp_pkg;

    localparam int MAX_NODES = 1024;
    localparam int MAX_LINKS = 8192;

    localparam int NODE_W   = $clog2(MAX_NODES);
    localparam int CNT_W    = $clog2(MAX_NODES + 1);
    localparam int LINK_AW  = $clog2(MAX_LINKS);
    localparam int LINK_W   = $clog2(MAX_LINKS + 1);

    localparam int FIELD_NODE_W = 10;
    localparam int COUNT_W      = 11;
    localparam int DEADLINE_W   = 26;
    localparam int OUT_DIST_W   = 26;
    localparam int HEIGHT_W     = 32;
    localparam int WEIGHT_W     = 16;
    localparam int RATE_W       = 16;
    localparam int CFG_DATA_W   = 32;

    localparam int DIST_W = 27;
    localparam int ND_W   = DIST_W + 1;
    localparam int PROD_W = RATE_W + ND_W;
    localparam int SUM_W  = ((PROD_W > HEIGHT_W) ? PROD_W : HEIGHT_W) + 1;

    localparam logic [DIST_W-1:0]     DIST_INF   = {DIST_W{1'b1}};
    localparam logic [OUT_DIST_W-1:0] DIST_SAT   = {OUT_DIST_W{1'b1}};
    localparam logic [LINK_W-1:0]     LINK_EMPTY = LINK_W'(MAX_LINKS);

    typedef enum logic [1:0] {
        ACT_NODE = 2'd0,
        ACT_EDGE = 2'd1,
        ACT_RUN  = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        CFG_NODE_COUNT  = 3'd0,
        CFG_SOURCE_NODE = 3'd1,
        CFG_TARGET_NODE = 3'd2,
        CFG_DEADLINE    = 3'd3,
        CFG_GROWTH_RATE = 3'd4
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EDGE_A,
        ST_EDGE_B,
        ST_INIT,
        ST_SCAN,
        ST_HEAD,
        ST_LINK,
        ST_RELAX1,
        ST_RELAX2,
        ST_FIN,
        ST_FIN2,
        ST_DONE
    } eng_state_t;

    typedef struct packed {
        logic [1:0]              action;
        logic [FIELD_NODE_W-1:0] node_index;
        logic [HEIGHT_W-1:0]     start_height;
        logic [HEIGHT_W-1:0]     height_limit;
        logic [FIELD_NODE_W-1:0] edge_from;
        logic [FIELD_NODE_W-1:0] edge_to;
        logic [WEIGHT_W-1:0]     edge_weight;
    } item_t;

    typedef struct packed {
        logic [COUNT_W-1:0]      node_count;
        logic [FIELD_NODE_W-1:0] source_node;
        logic [FIELD_NODE_W-1:0] target_node;
        logic [RATE_W-1:0]       growth_rate;
    } run_cfg_t;

    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic [HEIGHT_W-1:0] limit;
    } node_entry_t;

    typedef struct packed {
        logic [NODE_W-1:0]   dest;
        logic [LINK_W-1:0]   next;
        logic [WEIGHT_W-1:0] weight;
    } link_entry_t;

    typedef struct packed {
        logic              node_we;
        logic [NODE_W-1:0] node_waddr;
        node_entry_t       node_wdata;
        logic [NODE_W-1:0] node_raddr;
        logic              head_we;
        logic [NODE_W-1:0] head_waddr;
        logic [LINK_W-1:0] head_wdata;
        logic [NODE_W-1:0] head_raddr;
        logic               link_we;
        logic [LINK_AW-1:0] link_waddr;
        link_entry_t        link_wdata;
        logic [LINK_AW-1:0] link_raddr;
    } gmem_req_t;

    typedef struct packed {
        node_entry_t       node_rdata;
        logic [LINK_W-1:0] head_rdata;
        link_entry_t       link_rdata;
    } gmem_rsp_t;

endpackage

/* hdl/csp_graph.sv */
// ----------------------------------------------------------------------------
// csp_graph
// Graph store: node heights and limits, adjacency list heads and links.
// ----------------------------------------------------------------------------
module csp_graph (
    input  logic               clk,
    input  csp_pkg::gmem_req_t req,
    output csp_pkg::gmem_rsp_t rsp
);
    import csp_pkg::*;

    node_entry_t       node_mem [MAX_NODES];
    logic [LINK_W-1:0] head_mem [MAX_NODES];
    link_entry_t       link_mem [MAX_LINKS];

    always_ff @(posedge clk)
    begin
        if (req.node_we)
        begin
            node_mem[req.node_waddr] <= req.node_wdata;
        end
        if (req.head_we)
        begin
            head_mem[req.head_waddr] <= req.head_wdata;
        end
        if (req.link_we)
        begin
            link_mem[req.link_waddr] <= req.link_wdata;
        end
        rsp.node_rdata <= node_mem[req.node_raddr];
        rsp.head_rdata <= head_mem[req.head_raddr];
        rsp.link_rdata <= link_mem[req.link_raddr];
    end

endmodule

/* hdl/csp_engine.sv */
// ----------------------------------------------------------------------------
// csp_engine
// Load sequencer and search sequencer; keeps distances and settled marks.
// ----------------------------------------------------------------------------
module csp_engine (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  csp_pkg::item_t               item,
    input  csp_pkg::run_cfg_t            cfg,
    output logic                         res_valid,
    input  logic                         res_ready,
    output logic [csp_pkg::DIST_W-1:0]   res_dist,
    output csp_pkg::gmem_req_t           greq,
    input  csp_pkg::gmem_rsp_t           grsp
);
    import csp_pkg::*;

    eng_state_t          state_reg, state_next;
    logic [NODE_W-1:0]   clr_reg, clr_next;
    logic [LINK_W-1:0]   lc_reg, lc_next;
    logic [NODE_W-1:0]   ea_reg, ea_next, eb_reg, eb_next;
    logic [WEIGHT_W-1:0] ew_reg, ew_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next, idx_reg, idx_next;
    logic                pend_reg, pend_next;
    logic [NODE_W-1:0]   pidx_reg, pidx_next, u_reg, u_next, v_reg, v_next;
    logic [DIST_W-1:0]   bd_reg, bd_next, res_reg, res_next;
    logic [LINK_W-1:0]   nxt_reg, nxt_next;
    logic [ND_W-1:0]     nd_reg, nd_next;
    logic                cond_reg, cond_next;
    logic [HEIGHT_W-1:0] h_reg, h_next, lim_reg, lim_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;

    logic [DIST_W:0]     dist_mem [MAX_NODES];
    logic [DIST_W:0]     dist_rdata_reg;
    logic                dist_we;
    logic [NODE_W-1:0]   dist_waddr, dist_raddr;
    logic [DIST_W:0]     dist_wdata;

    logic                accept;
    logic [CNT_W-1:0]    cnt_c;
    logic [NODE_W-1:0]   src, tgt;
    logic [SUM_W-1:0]    sum_c;
    logic                ok_c;
    logic [LINK_W:0]     lc_plus2;

    always_ff @(posedge clk)
    begin
        if (dist_we)
        begin
            dist_mem[dist_waddr] <= dist_wdata;
        end
        dist_rdata_reg <= dist_mem[dist_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            lc_reg    <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            lc_reg    <= lc_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ea_reg   <= ea_next;
        eb_reg   <= eb_next;
        ew_reg   <= ew_next;
        cnt_reg  <= cnt_next;
        idx_reg  <= idx_next;
        pidx_reg <= pidx_next;
        u_reg    <= u_next;
        v_reg    <= v_next;
        bd_reg   <= bd_next;
        res_reg  <= res_next;
        nxt_reg  <= nxt_next;
        nd_reg   <= nd_next;
        cond_reg <= cond_next;
        h_reg    <= h_next;
        lim_reg  <= lim_next;
        prod_reg <= prod_next;
    end

    assign src       = NODE_W'(cfg.source_node);
    assign tgt       = NODE_W'(cfg.target_node);
    assign accept    = item_valid && !item_stall;
    assign item_stall = (state_reg != ST_IDLE);
    assign res_dist  = res_reg;
    assign lc_plus2  = {1'b0, lc_reg} + (LINK_W + 1)'(2);
    assign sum_c     = SUM_W'(h_reg) + SUM_W'(prod_reg);
    assign ok_c      = (v_reg == tgt) || (sum_c <= SUM_W'(lim_reg));

    always_comb
    begin
        if (cfg.node_count == '0)
        begin
            cnt_c = CNT_W'(1);
        end
        else if (32'(cfg.node_count) > MAX_NODES)
        begin
            cnt_c = CNT_W'(MAX_NODES);
        end
        else
        begin
            cnt_c = CNT_W'(cfg.node_count);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        lc_next    = lc_reg;
        ea_next    = ea_reg;
        eb_next    = eb_reg;
        ew_next    = ew_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        pend_next  = 1'b0;
        pidx_next  = pidx_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        bd_next    = bd_reg;
        res_next   = res_reg;
        nxt_next   = nxt_reg;
        nd_next    = nd_reg;
        cond_next  = cond_reg;
        h_next     = h_reg;
        lim_next   = lim_reg;
        prod_next  = prod_reg;
        res_valid  = 1'b0;
        dist_we    = 1'b0;
        dist_waddr = u_reg;
        dist_wdata = {1'b1, bd_reg};
        dist_raddr = pidx_reg;
        greq       = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                greq.head_we    = 1'b1;
                greq.head_waddr = clr_reg;
                greq.head_wdata = LINK_EMPTY;
                clr_next = clr_reg + NODE_W'(1);
                if (32'(clr_reg) == MAX_NODES - 1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item.action)
                        ACT_NODE:
                        begin
                            if (32'(item.node_index) < MAX_NODES)
                            begin
                                greq.node_we    = 1'b1;
                                greq.node_waddr = NODE_W'(item.node_index);
                                greq.node_wdata = '{height: item.start_height,
                                                    limit:  item.height_limit};
                            end
                        end
                        ACT_EDGE:
                        begin
                            if (32'(item.edge_from) < MAX_NODES &&
                                32'(item.edge_to) < MAX_NODES &&
                                32'(lc_plus2) <= MAX_LINKS)
                            begin
                                ea_next = NODE_W'(item.edge_from);
                                eb_next = NODE_W'(item.edge_to);
                                ew_next = item.edge_weight;
                                greq.head_raddr = NODE_W'(item.edge_from);
                                state_next = ST_EDGE_A;
                            end
                        end
                        ACT_RUN:
                        begin
                            if (32'(cfg.source_node) >= 32'(cnt_c) ||
                                32'(cfg.target_node) >= 32'(cnt_c))
                            begin
                                res_next   = DIST_INF;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                cnt_next   = cnt_c;
                                idx_next   = '0;
                                state_next = ST_INIT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_EDGE_A:
            begin
                greq.link_we    = 1'b1;
                greq.link_waddr = lc_reg[LINK_AW-1:0];
                greq.link_wdata = '{dest: eb_reg, next: grsp.head_rdata, weight: ew_reg};
                greq.head_we    = 1'b1;
                greq.head_waddr = ea_reg;
                greq.head_wdata = lc_reg;
                greq.head_raddr = eb_reg;
                state_next = ST_EDGE_B;
            end

            ST_EDGE_B:
            begin
                // self loop: head of b was just rewritten
                greq.link_we    = 1'b1;
                greq.link_waddr = lc_plus2[LINK_AW-1:0] - LINK_AW'(1);
                greq.link_wdata = '{dest: ea_reg,
                                    next: (ea_reg == eb_reg) ? lc_reg : grsp.head_rdata,
                                    weight: ew_reg};
                greq.head_we    = 1'b1;
                greq.head_waddr = eb_reg;
                greq.head_wdata = lc_reg + LINK_W'(1);
                lc_next    = lc_plus2[LINK_W-1:0];
                state_next = ST_IDLE;
            end

            ST_INIT:
            begin
                dist_we    = 1'b1;
                dist_waddr = idx_reg[NODE_W-1:0];
                dist_wdata = {1'b0, (idx_reg[NODE_W-1:0] == src) ? DIST_W'(0) : DIST_INF};
                idx_next   = idx_reg + CNT_W'(1);
                if (idx_reg == cnt_reg - CNT_W'(1))
                begin
                    idx_next   = '0;
                    bd_next    = DIST_INF;
                    u_next     = '0;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (pend_reg && !dist_rdata_reg[DIST_W] &&
                    dist_rdata_reg[DIST_W-1:0] < bd_reg)
                begin
                    bd_next = dist_rdata_reg[DIST_W-1:0];
                    u_next  = pidx_reg;
                end
                if (idx_reg < cnt_reg)
                begin
                    dist_raddr = idx_reg[NODE_W-1:0];
                    idx_next   = idx_reg + CNT_W'(1);
                    pend_next  = 1'b1;
                    pidx_next  = idx_reg[NODE_W-1:0];
                end
                else if (!pend_reg)
                begin
                    if (bd_reg == DIST_INF)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        dist_we         = 1'b1;
                        dist_waddr      = u_reg;
                        dist_wdata      = {1'b1, bd_reg};
                        greq.head_raddr = u_reg;
                        state_next      = ST_HEAD;
                    end
                end
            end

            ST_HEAD:
            begin
                if (grsp.head_rdata == LINK_EMPTY)
                begin
                    idx_next   = '0;
                    bd_next    = DIST_INF;
                    u_next     = '0;
                    state_next = ST_SCAN;
                end
                else
                begin
                    greq.link_raddr = grsp.head_rdata[LINK_AW-1:0];
                    state_next      = ST_LINK;
                end
            end

            ST_LINK:
            begin
                v_next   = grsp.link_rdata.dest;
                nxt_next = grsp.link_rdata.next;
                nd_next  = ND_W'(bd_reg) + ND_W'(grsp.link_rdata.weight);
                if (32'(grsp.link_rdata.dest) >= 32'(cnt_reg))
                begin
                    if (grsp.link_rdata.next == LINK_EMPTY)
                    begin
                        idx_next   = '0;
                        bd_next    = DIST_INF;
                        u_next     = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        greq.link_raddr = grsp.link_rdata.next[LINK_AW-1:0];
                    end
                end
                else
                begin
                    dist_raddr      = grsp.link_rdata.dest;
                    greq.node_raddr = grsp.link_rdata.dest;
                    state_next      = ST_RELAX1;
                end
            end

            ST_RELAX1:
            begin
                prod_next  = PROD_W'(nd_reg) * PROD_W'(cfg.growth_rate);
                cond_next  = !dist_rdata_reg[DIST_W] &&
                             (nd_reg < ND_W'(dist_rdata_reg[DIST_W-1:0]));
                h_next     = grsp.node_rdata.height;
                lim_next   = grsp.node_rdata.limit;
                state_next = ST_RELAX2;
            end

            ST_RELAX2:
            begin
                if (cond_reg && ok_c)
                begin
                    dist_we    = 1'b1;
                    dist_waddr = v_reg;
                    dist_wdata = {1'b0, nd_reg[DIST_W-1:0]};
                end
                if (nxt_reg == LINK_EMPTY)
                begin
                    idx_next   = '0;
                    bd_next    = DIST_INF;
                    u_next     = '0;
                    state_next = ST_SCAN;
                end
                else
                begin
                    greq.link_raddr = nxt_reg[LINK_AW-1:0];
                    state_next      = ST_LINK;
                end
            end

            ST_FIN:
            begin
                dist_raddr = tgt;
                state_next = ST_FIN2;
            end

            ST_FIN2:
            begin
                res_next   = dist_rdata_reg[DIST_W-1:0];
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/constrained_shortest_path.sv */
// ----------------------------------------------------------------------------
// constrained_shortest_path
// Shortest path search with a per-node height limit over a stored graph.
// ----------------------------------------------------------------------------
// node load: a single node write; edge load: two head read-modify-writes
// run: init of the N distances, then per settled node a scan and list head read,
//   each link to a node in use relaxed and other links skipped; final scan and target read
// result beat registered from the engine result, N = node count
// reset: all 1024 list heads cleared, input stalled meanwhile
module constrained_shortest_path (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           action,
    input  logic [csp_pkg::FIELD_NODE_W-1:0]     node_index,
    input  logic [csp_pkg::HEIGHT_W-1:0]         start_height,
    input  logic [csp_pkg::HEIGHT_W-1:0]         height_limit,
    input  logic [csp_pkg::FIELD_NODE_W-1:0]     edge_from,
    input  logic [csp_pkg::FIELD_NODE_W-1:0]     edge_to,
    input  logic [csp_pkg::WEIGHT_W-1:0]         edge_weight,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 within_deadline,
    output logic [csp_pkg::OUT_DIST_W-1:0]       distance,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [2:0]                           cfg_index,
    input  logic [csp_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import csp_pkg::*;

    logic [COUNT_W-1:0]      node_count_reg;
    logic [FIELD_NODE_W-1:0] source_node_reg, target_node_reg;
    logic [DEADLINE_W-1:0]   deadline_reg;
    logic [RATE_W-1:0]       growth_rate_reg;
    logic                    out_valid_reg;
    logic                    within_reg;
    logic [OUT_DIST_W-1:0]   dist_reg;

    item_t              item;
    run_cfg_t           run_cfg;
    gmem_req_t          greq;
    gmem_rsp_t          grsp;
    logic               res_valid, res_ready;
    logic [DIST_W-1:0]  res_dist;

    assign cfg_ready = 1'b1;
    assign item = '{action: action, node_index: node_index, start_height: start_height,
                    height_limit: height_limit, edge_from: edge_from, edge_to: edge_to,
                    edge_weight: edge_weight};
    assign run_cfg = '{node_count: node_count_reg, source_node: source_node_reg,
                       target_node: target_node_reg, growth_rate: growth_rate_reg};
    assign res_ready       = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign within_deadline = within_reg;
    assign distance        = dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg  <= COUNT_W'(1);
            source_node_reg <= '0;
            target_node_reg <= '0;
            deadline_reg    <= '0;
            growth_rate_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_NODE_COUNT:  node_count_reg  <= cfg_data[COUNT_W-1:0];
                CFG_SOURCE_NODE: source_node_reg <= cfg_data[FIELD_NODE_W-1:0];
                CFG_TARGET_NODE: target_node_reg <= cfg_data[FIELD_NODE_W-1:0];
                CFG_DEADLINE:    deadline_reg    <= cfg_data[DEADLINE_W-1:0];
                CFG_GROWTH_RATE: growth_rate_reg <= cfg_data[RATE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            within_reg <= (res_dist != DIST_INF) &&
                          (res_dist <= DIST_W'(deadline_reg));
            dist_reg   <= (res_dist > DIST_W'(DIST_SAT)) ? DIST_SAT
                                                         : res_dist[OUT_DIST_W-1:0];
        end
    end

    csp_graph u_graph (
        .clk (clk),
        .req (greq),
        .rsp (grsp)
    );

    csp_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid),
        .item_stall (in_stall),
        .item       (item),
        .cfg        (run_cfg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_dist   (res_dist),
        .greq       (greq),
        .grsp       (grsp)
    );

    a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && action == ACT_RUN) |=> in_stall)
        else $error("run beat did not block the input");

    a_out_from_engine: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(res_valid))
        else $error("result beat without engine result");

    a_no_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> in_stall)
        else $error("engine result while accepting input");

endmodule

/* test/constrained_shortest_path_tb.sv */
// ----------------------------------------------------------------------------
// constrained_shortest_path_tb
// Loads node heights and limits and undirected edges into the block, runs
// searches under several register settings and compares every result beat
// with a behavioral Dijkstra search that applies the same height limit,
// with random gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module constrained_shortest_path_tb;
    import csp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned NO_PATH = 64'd9000000000000000000;

    typedef struct {
        logic                  ok;
        logic [OUT_DIST_W-1:0] path_len;
    } path_result_t;

    class path_scoreboard;
        logic [31:0] heights [MAX_NODES];
        logic [31:0] limits [MAX_NODES];
        bit          loaded [MAX_NODES];
        int          heads [MAX_NODES];
        int          dests [MAX_LINKS];
        int          nexts [MAX_LINKS];
        int          weights [MAX_LINKS];
        int          nlinks;
        int          node_count, source_node, target_node, growth_rate;
        longint unsigned deadline;
        path_result_t    pending [$];
        int              errors;

        function void init();
            for (int i = 0; i < MAX_NODES; i++)
            begin
                heads[i] = MAX_LINKS;
                loaded[i] = 0;
            end
            nlinks = 0;
            node_count = 1;
            source_node = 0;
            target_node = 0;
            deadline = 0;
            growth_rate = 0;
            errors = 0;
        endfunction

        function int nodes_in_use();
            if (node_count == 0)
                return 1;
            if (node_count > MAX_NODES)
                return MAX_NODES;
            return node_count;
        endfunction

        function void set_reg(cfg_index_t idx, logic [31:0] val);
            case (idx)
                CFG_NODE_COUNT:  node_count = int'(val[10:0]);
                CFG_SOURCE_NODE: source_node = int'(val[9:0]);
                CFG_TARGET_NODE: target_node = int'(val[9:0]);
                CFG_DEADLINE:    deadline = 64'(val[25:0]);
                CFG_GROWTH_RATE: growth_rate = int'(val[15:0]);
                default: ;
            endcase
        endfunction

        function void add_link(int from, int to, int wt);
            dests[nlinks] = to;
            nexts[nlinks] = heads[from];
            weights[nlinks] = wt;
            heads[from] = nlinks;
            nlinks++;
        endfunction

        function longint unsigned shortest_distance();
            longint unsigned best [MAX_NODES];
            bit              done [MAX_NODES];
            longint unsigned bd, nd;
            int              cnt, u, v, k;
            cnt = nodes_in_use();
            for (int i = 0; i < MAX_NODES; i++)
            begin
                best[i] = NO_PATH;
                done[i] = 0;
            end
            if (source_node >= cnt || target_node >= cnt)
                return NO_PATH;
            best[source_node] = 0;
            forever
            begin
                u = cnt;
                bd = NO_PATH;
                for (int i = 0; i < cnt; i++)
                    if (!done[i] && best[i] < bd)
                    begin
                        bd = best[i];
                        u = i;
                    end
                if (u >= cnt)
                    break;
                done[u] = 1;
                k = heads[u];
                while (k < MAX_LINKS && k < nlinks)
                begin
                    v = dests[k];
                    nd = bd + weights[k];
                    if (!(v >= cnt || done[v] || nd >= best[v]))
                        if (v == target_node || longint'(heights[v])
                            + longint'(growth_rate) * nd <= longint'(limits[v]))
                            best[v] = nd;
                    k = nexts[k];
                end
            end
            return best[target_node];
        endfunction

        function void note_item(logic [1:0] act, logic [9:0] nidx, logic [31:0] h,
                                logic [31:0] l, logic [9:0] a, logic [9:0] b,
                                logic [15:0] w);
            longint unsigned d;
            path_result_t    r;
            case (act)
                ACT_NODE:
                begin
                    heights[nidx] = h;
                    limits[nidx] = l;
                    loaded[nidx] = 1;
                end
                ACT_EDGE:
                    if (nlinks + 2 <= MAX_LINKS)
                    begin
                        add_link(a, b, w);
                        add_link(b, a, w);
                    end
                ACT_RUN:
                begin
                    d = shortest_distance();
                    r.ok = (d != NO_PATH) && (d <= deadline);
                    r.path_len = (d > 64'(DIST_SAT)) ? DIST_SAT : d[OUT_DIST_W-1:0];
                    pending.push_back(r);
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic ok, logic [OUT_DIST_W-1:0] path_len);
            path_result_t e;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: ok %0d distance %0d", ok, path_len);
                return;
            end
            e = pending.pop_front();
            if (ok !== e.ok || path_len !== e.path_len)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected ok %0d distance %0d, got ok %0d distance %0d",
                             e.ok, e.path_len, ok, path_len);
            end
        endfunction
    endclass

    logic                  clk = 0;
    logic                  rst_n = 0;
    logic                  in_valid = 0;
    logic                  in_stall;
    logic [1:0]            action = 0;
    logic [9:0]            node_index = 0;
    logic [31:0]           start_height = 0;
    logic [31:0]           height_limit = 0;
    logic [9:0]            edge_from = 0;
    logic [9:0]            edge_to = 0;
    logic [15:0]           edge_weight = 0;
    logic                  out_valid;
    logic                  out_stall = 0;
    logic                  within_deadline;
    logic [OUT_DIST_W-1:0] distance;
    logic                  cfg_valid = 0;
    logic                  cfg_ready;
    logic [2:0]            cfg_index = 0;
    logic [31:0]           cfg_data = 0;

    path_scoreboard sb = new();
    bit             calm = 0;
    int             stall_left = 0;

    constrained_shortest_path uut (.*);

    always #6 clk = ~clk;

    initial
    begin
        #400_000_000;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
            sb.note_item(action, node_index, start_height, height_limit,
                         edge_from, edge_to, edge_weight);
        if (out_valid && !out_stall)
            sb.check_result(within_deadline, distance);
    end

    // result side stalls, mostly short bursts, now and then a long one
    always @(negedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (!calm && $urandom_range(0, 99) < 25)
        begin
            out_stall = 1;
            stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 3);
        end
        else
            out_stall = 0;
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 1000);
            default: return $urandom;
        endcase
    endfunction

    task send_item(action_t act, int nidx, logic [31:0] h, logic [31:0] l,
                   int a, int b, int w);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 0;
            repeat (gap) @(negedge clk);
        end
        action = act;
        node_index = 10'(nidx);
        start_height = h;
        height_limit = l;
        edge_from = 10'(a);
        edge_to = 10'(b);
        edge_weight = 16'(w);
        in_valid = 1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task send_raw(logic [1:0] act);
        @(negedge clk);
        action = act;
        node_index = 10'($urandom);
        start_height = $urandom;
        height_limit = $urandom;
        edge_from = 10'($urandom);
        edge_to = 10'($urandom);
        edge_weight = 16'($urandom);
        in_valid = 1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task load_node(int idx);
        logic [31:0] h, l;
        h = $urandom_range(0, 1000);
        case ($urandom_range(0, 3))
            0: l = 32'hFFFF_FFFF;
            1: l = h;
            default: l = h + $urandom_range(0, 300000);
        endcase
        send_item(ACT_NODE, idx, h, l, $urandom, $urandom, $urandom);
    endtask

    task send_edge(int a, int b);
        int w;
        case ($urandom_range(0, 7))
            0: w = 0;
            1: w = 16'hFFFF;
            2: w = $urandom_range(0, 65535);
            default: w = $urandom_range(1, 500);
        endcase
        send_item(ACT_EDGE, $urandom, $urandom, $urandom, a, b, w);
    endtask

    task send_run();
        send_item(ACT_RUN, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    task write_reg(cfg_index_t idx, logic [31:0] val);
        @(negedge clk);
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    task drain();
        @(negedge clk);
        in_valid = 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task load_missing();
        for (int i = 0; i < sb.nodes_in_use(); i++)
            if (!sb.loaded[i])
                load_node(i);
    endtask

    task setup(int ncount, int src, int tgt, logic [31:0] dl, logic [31:0] rate);
        drain();
        write_reg(CFG_NODE_COUNT, ncount);
        write_reg(CFG_SOURCE_NODE, src);
        write_reg(CFG_TARGET_NODE, tgt);
        write_reg(CFG_DEADLINE, dl);
        write_reg(CFG_GROWTH_RATE, rate);
        load_missing();
    endtask

    task random_phase(int items);
        int cnt, r;
        cnt = sb.nodes_in_use();
        calm = ($urandom_range(0, 3) == 0);
        for (int n = 0; n < items; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_edge($urandom_range(0, 1023), $urandom_range(0, cnt - 1));
                else
                    send_edge($urandom_range(0, cnt - 1), $urandom_range(0, cnt - 1));
            end
            else if (r < 70)
                load_node(($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                                      : $urandom_range(0, cnt - 1));
            else if (r < 97)
                send_run();
            else
                send_raw(2'd3);
        end
        calm = 0;
    endtask

    function logic [31:0] pick_deadline();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 26'h3FF_FFFF;
            default: return $urandom_range(0, 3000);
        endcase
    endfunction

    function logic [31:0] pick_rate();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 16'hFFFF;
            default: return $urandom_range(0, 20);
        endcase
    endfunction

    initial
    begin
        int cnt, src, tgt;
        sb.init();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: reset settings, ignored action, extremes, out of use nodes
        send_run();
        send_raw(2'd3);
        setup(4, 0, 3, 26'h3FF_FFFF, 16'hFFFF);
        send_item(ACT_NODE, 1, 32'h0, 32'hFFFF_FFFF, 0, 0, 0);
        send_item(ACT_NODE, 2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
        send_item(ACT_NODE, 1023, 32'hFFFF_FFFF, 32'h0, 0, 0, 0);
        send_run();
        send_item(ACT_EDGE, 0, 0, 0, 0, 1, 0);
        send_item(ACT_EDGE, 0, 0, 0, 1, 3, 16'hFFFF);
        send_item(ACT_EDGE, 0, 0, 0, 0, 2, 1);
        send_item(ACT_EDGE, 0, 0, 0, 2, 3, 5);
        send_item(ACT_EDGE, 0, 0, 0, 3, 1023, 7);
        send_run();

        // whole node range and a count above range, every reachable node loaded
        drain();
        write_reg(CFG_NODE_COUNT, 11'h7FF);
        write_reg(CFG_TARGET_NODE, 1023);
        send_run();
        drain();
        write_reg(CFG_NODE_COUNT, 1024);
        send_run();
        drain();
        write_reg(CFG_TARGET_NODE, 1000);
        send_run();

        setup(4, 0, 3, 0, 0);
        send_run();
        setup(4, 0, 3, 5, 0);
        send_run();
        setup(4, 3, 7, 5, 0);
        send_run();
        setup(0, 0, 0, 0, 0);
        send_run();

        for (int p = 0; p < 14; p++)
        begin
            cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 80) : $urandom_range(2, 24);
            src = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                              : $urandom_range(0, cnt - 1);
            tgt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                              : $urandom_range(0, cnt - 1);
            setup(cnt, src, tgt, pick_deadline(), pick_rate());
            random_phase(70);
        end

        random_phase(40);

        drain();
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
hdl/csp_pkg.sv
hdl/csp_graph.sv
hdl/csp_engine.sv
hdl/constrained_shortest_path.sv
test/constrained_shortest_path_tb.sv
